// ----- hdl/sca_pkg.sv -----
package sca_pkg;

   localparam int MaxSpeedDefault = 64;
   localparam int CoordBitsDefault = 16;

   localparam int PosW = 16;
   localparam int VelW = 12;
   localparam int DistW = 17;
   localparam int FracOne = 16;

   // Squared distance of one sample and the integer root taken from it.
   localparam int SqW = 35;
   localparam int RootW = (SqW + 1) / 2;

endpackage

// ----- hdl/sca_isqrt.sv -----
module sca_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sca_pkg::SqW-1:0]    radicand,
   output logic                       done,
   output logic [sca_pkg::RootW-1:0]  root
);
   import sca_pkg::*;

   localparam int TopBitPos = ((SqW - 1) / 2) * 2;
   localparam logic [SqW-1:0] TopBit = SqW'(1) << TopBitPos;

   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [SqW-1:0] rad_ff, rad_in;
   logic [SqW-1:0] acc_ff, acc_in;
   logic [SqW-1:0] bit_ff, bit_in;
   logic [SqW:0]   trial;

   // One result bit per cycle, from the top even bit position downwards.
   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      rad_in = rad_ff;
      acc_in = acc_ff;
      bit_in = bit_ff;
      trial = {1'b0, acc_ff} + {1'b0, bit_ff};
      if (start) begin
         run_in = 1'b1;
         rad_in = radicand;
         acc_in = '0;
         bit_in = TopBit;
      end else if (run_ff) begin
         if ({1'b0, rad_ff} >= trial) begin
            rad_in = rad_ff - trial[SqW-1:0];
            acc_in = (acc_ff >> 1) + bit_ff;
         end else begin
            acc_in = acc_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = acc_ff[RootW-1:0];

endmodule

// ----- hdl/sampled_closest_approach.sv -----
// Processes one item at a time: a new request is taken only in the idle state, once the
// result of the last one has been loaded into the output register. The step division
// works one quotient bit at a time for each of the four lanes, the sample loop takes
// N = floor(D/16) + 1 samples on one shared multiplier, where D is the largest clamped
// velocity component, and the square root takes 18 steps before the result is registered.
// Reset is synchronous and clears the sequencer and the result valid flag.
module sampled_closest_approach #(
   parameter int MAX_SPEED = sca_pkg::MaxSpeedDefault,
   parameter int COORD_BITS = sca_pkg::CoordBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sca_pkg::PosW-1:0]     req_first_pos_x,
   input  logic signed [sca_pkg::PosW-1:0]     req_first_pos_y,
   input  logic signed [sca_pkg::VelW-1:0]     req_first_vel_x,
   input  logic signed [sca_pkg::VelW-1:0]     req_first_vel_y,
   input  logic signed [sca_pkg::PosW-1:0]     req_second_pos_x,
   input  logic signed [sca_pkg::PosW-1:0]     req_second_pos_y,
   input  logic signed [sca_pkg::VelW-1:0]     req_second_vel_x,
   input  logic signed [sca_pkg::VelW-1:0]     req_second_vel_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sca_pkg::DistW-1:0]           rsp_closest_distance
);
   import sca_pkg::*;

   localparam int Lanes = 4;
   localparam int MagW = VelW;
   localparam int IdxW = MagW - 4;
   localparam int NumW = MagW + 4;
   localparam int QW = 5;
   localparam int DiffW = PosW + 1;
   localparam int ProdW = 2 * DiffW;
   localparam logic signed [NumW-1:0] VelLim = NumW'(MAX_SPEED * FracOne);
   localparam logic [RootW-1:0] DistMax = (COORD_BITS + 1 >= RootW) ? '1 :
      RootW'((64'(1) << (COORD_BITS + 1)) - 64'(1));

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIV  = 8'b0000_0010,
      ST_LOAD = 8'b0000_0100,
      ST_MULX = 8'b0000_1000,
      ST_MULY = 8'b0001_0000,
      ST_FIN  = 8'b0010_0000,
      ST_ROOT = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DistW-1:0]        dist_ff, dist_in;

   logic signed [PosW-1:0]  pos_ff [Lanes], pos_in [Lanes];
   logic                    neg_ff [Lanes], neg_in [Lanes];
   logic [MagW-1:0]         mag_ff [Lanes], mag_in [Lanes];
   logic [QW-1:0]           qs_ff [Lanes], qs_in [Lanes];
   logic [MagW-1:0]         rs_ff [Lanes], rs_in [Lanes];
   logic [MagW-1:0]         accq_ff [Lanes], accq_in [Lanes];
   logic [MagW-1:0]         accr_ff [Lanes], accr_in [Lanes];
   logic [MagW-1:0]         d_ff, d_in;
   logic [IdxW-1:0]         last_ff, last_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [1:0]              lane_ff, lane_in;
   logic [2:0]              k_ff, k_in;
   logic [NumW-1:0]         rem_ff, rem_in;
   logic [QW-2:0]           qpart_ff, qpart_in;
   logic [DiffW-1:0]        adx_ff, adx_in, ady_ff, ady_in;
   logic [ProdW-1:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SqW-1:0]          best_ff, best_in;

   logic signed [VelW-1:0]  vel_req [Lanes];
   logic signed [PosW-1:0]  pos_req [Lanes];
   logic signed [NumW-1:0]  vext, vclamp;
   logic [MagW-1:0]         mag_req [Lanes];
   logic                    neg_req [Lanes];
   logic [MagW-1:0]         dmax;

   logic [NumW-1:0]         cur_rem, den, rem_nx;
   logic [QW-2:0]           cur_q;
   logic                    take;

   logic [MagW:0]           rsum [Lanes];
   logic                    wrap [Lanes];
   logic [MagW-1:0]         stepq [Lanes], stepr [Lanes];
   logic signed [MagW:0]    off [Lanes];
   logic signed [DiffW+1:0] ax, ay, bx, by, dxs, dys, dxa, dya;

   logic [DiffW-1:0]        mul_a;
   logic [ProdW-1:0]        prod;
   logic [SqW-1:0]          sqsum;
   logic                    better;

   logic                    root_start, root_done;
   logic [SqW-1:0]          root_arg;
   logic [RootW-1:0]        root, root_sat;

   sca_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_arg),
      .done     (root_done),
      .root     (root)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_closest_distance = dist_ff;

   always_comb begin
      vel_req[0] = req_first_vel_x;
      vel_req[1] = req_first_vel_y;
      vel_req[2] = req_second_vel_x;
      vel_req[3] = req_second_vel_y;
      pos_req[0] = req_first_pos_x;
      pos_req[1] = req_first_pos_y;
      pos_req[2] = req_second_pos_x;
      pos_req[3] = req_second_pos_y;
      dmax = '0;
      vext = '0;
      vclamp = '0;
      for (int l = 0; l < Lanes; l++) begin
         vext = NumW'(vel_req[l]);
         if (vext > VelLim) begin
            vclamp = VelLim;
         end else if (vext < -VelLim) begin
            vclamp = -VelLim;
         end else begin
            vclamp = vext;
         end
         neg_req[l] = vclamp[NumW-1];
         mag_req[l] = neg_req[l] ? MagW'(-vclamp) : MagW'(vclamp);
         if (mag_req[l] > dmax) begin
            dmax = mag_req[l];
         end
      end
      if (dmax == '0) begin
         dmax = MagW'(1);
      end
   end

   // Step quotient and remainder of 16*|v|/D, one quotient bit per cycle.
   always_comb begin
      cur_rem = (k_ff == 3'd4) ? {mag_ff[lane_ff], 4'b0000} : rem_ff;
      cur_q = (k_ff == 3'd4) ? '0 : qpart_ff;
      den = NumW'(d_ff) << k_ff;
      take = (cur_rem >= den);
      rem_nx = take ? cur_rem - den : cur_rem;
   end

   // Running offsets: accq*D + accr equals 16*|v|*i for the next sample.
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         rsum[l] = {1'b0, accr_ff[l]} + {1'b0, rs_ff[l]};
         wrap[l] = (rsum[l] >= {1'b0, d_ff});
         stepr[l] = wrap[l] ? MagW'(rsum[l] - {1'b0, d_ff}) : rsum[l][MagW-1:0];
         stepq[l] = accq_ff[l] + MagW'(qs_ff[l]) + MagW'(wrap[l]);
         off[l] = neg_ff[l] ? -$signed({1'b0, accq_ff[l]}) : $signed({1'b0, accq_ff[l]});
      end
      ax = (DiffW+2)'(pos_ff[0]) + (DiffW+2)'(off[0]);
      ay = (DiffW+2)'(pos_ff[1]) + (DiffW+2)'(off[1]);
      bx = (DiffW+2)'(pos_ff[2]) + (DiffW+2)'(off[2]);
      by = (DiffW+2)'(pos_ff[3]) + (DiffW+2)'(off[3]);
      dxs = ax - bx;
      dys = ay - by;
      dxa = dxs[DiffW+1] ? -dxs : dxs;
      dya = dys[DiffW+1] ? -dys : dys;
   end

   always_comb begin
      mul_a = (state_ff == ST_MULX) ? adx_ff : ady_ff;
      prod = ProdW'(mul_a) * ProdW'(mul_a);
      sqsum = SqW'(sqx_ff) + SqW'(sqy_ff);
      better = (sqsum < best_ff);
      root_sat = (root > DistMax) ? DistMax : root;
   end

   always_comb begin
      state_in = state_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dist_in = dist_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      qs_in = qs_ff;
      rs_in = rs_ff;
      accq_in = accq_ff;
      accr_in = accr_ff;
      d_in = d_ff;
      last_in = last_ff;
      idx_in = idx_ff;
      lane_in = lane_ff;
      k_in = k_ff;
      rem_in = rem_ff;
      qpart_in = qpart_ff;
      adx_in = adx_ff;
      ady_in = ady_ff;
      sqx_in = sqx_ff;
      sqy_in = sqy_ff;
      best_in = best_ff;
      root_start = 1'b0;
      root_arg = best_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in = pos_req;
               neg_in = neg_req;
               mag_in = mag_req;
               d_in = dmax;
               last_in = dmax[MagW-1:4];
               idx_in = '0;
               lane_in = '0;
               k_in = 3'd4;
               for (int l = 0; l < Lanes; l++) begin
                  accq_in[l] = '0;
                  accr_in[l] = '0;
               end
               best_in = '1;
               pend_in = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_nx;
            qpart_in = {cur_q[QW-3:0], take};
            if (k_ff == 3'd0) begin
               qs_in[lane_ff] = {cur_q, take};
               rs_in[lane_ff] = rem_nx[MagW-1:0];
               k_in = 3'd4;
               lane_in = lane_ff + 2'd1;
               if (lane_ff == 2'(Lanes - 1)) begin
                  state_in = ST_LOAD;
               end
            end else begin
               k_in = k_ff - 3'd1;
            end
         end
         ST_LOAD: begin
            adx_in = dxa[DiffW-1:0];
            ady_in = dya[DiffW-1:0];
            accq_in = stepq;
            accr_in = stepr;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            sqx_in = prod;
            if (pend_ff && better) begin
               best_in = sqsum;
            end
            pend_in = 1'b0;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            sqy_in = prod;
            pend_in = 1'b1;
            adx_in = dxa[DiffW-1:0];
            ady_in = dya[DiffW-1:0];
            accq_in = stepq;
            accr_in = stepr;
            idx_in = idx_ff + IdxW'(1);
            state_in = (idx_ff == last_ff) ? ST_FIN : ST_MULX;
         end
         ST_FIN: begin
            if (better) begin
               best_in = sqsum;
            end
            pend_in = 1'b0;
            root_start = 1'b1;
            root_arg = best_in;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               dist_in = root_sat[DistW-1:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      qs_ff <= qs_in;
      rs_ff <= rs_in;
      accq_ff <= accq_in;
      accr_ff <= accr_in;
      d_ff <= d_in;
      last_ff <= last_in;
      idx_ff <= idx_in;
      lane_ff <= lane_in;
      k_ff <= k_in;
      rem_ff <= rem_in;
      qpart_ff <= qpart_in;
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      best_ff <= best_in;
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int VelLimit = sca_pkg::MaxSpeedDefault * sca_pkg::FracOne;
   localparam longint DistMax = (64'd1 << (sca_pkg::CoordBitsDefault + 1)) - 1;
   localparam int RandomEncounters = 1150;
   localparam int DrainCycles = 250;
   localparam int PressureAfter = 300;
   localparam int PressureCycles = 600;

   typedef struct {
      logic signed [sca_pkg::PosW-1:0] p1x;
      logic signed [sca_pkg::PosW-1:0] p1y;
      logic signed [sca_pkg::VelW-1:0] v1x;
      logic signed [sca_pkg::VelW-1:0] v1y;
      logic signed [sca_pkg::PosW-1:0] p2x;
      logic signed [sca_pkg::PosW-1:0] p2y;
      logic signed [sca_pkg::VelW-1:0] v2x;
      logic signed [sca_pkg::VelW-1:0] v2y;
      bit known;
      logic [sca_pkg::DistW-1:0] given_dist;
   } encounter_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [sca_pkg::PosW-1:0] req_first_pos_x = '0;
   logic signed [sca_pkg::PosW-1:0] req_first_pos_y = '0;
   logic signed [sca_pkg::VelW-1:0] req_first_vel_x = '0;
   logic signed [sca_pkg::VelW-1:0] req_first_vel_y = '0;
   logic signed [sca_pkg::PosW-1:0] req_second_pos_x = '0;
   logic signed [sca_pkg::PosW-1:0] req_second_pos_y = '0;
   logic signed [sca_pkg::VelW-1:0] req_second_vel_x = '0;
   logic signed [sca_pkg::VelW-1:0] req_second_vel_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [sca_pkg::DistW-1:0] rsp_closest_distance;

   logic [sca_pkg::DistW-1:0] distance_q[$];
   encounter_type directed[$];
   int fail_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int clipped_count = 0;
   int single_sample_count = 0;

   sampled_closest_approach u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_first_pos_x      (req_first_pos_x),
      .req_first_pos_y      (req_first_pos_y),
      .req_first_vel_x      (req_first_vel_x),
      .req_first_vel_y      (req_first_vel_y),
      .req_second_pos_x     (req_second_pos_x),
      .req_second_pos_y     (req_second_pos_y),
      .req_second_vel_x     (req_second_vel_x),
      .req_second_vel_y     (req_second_vel_y),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_closest_distance (rsp_closest_distance)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #25_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic encounter_type row(input int ax, input int ay, input int avx, input int avy,
                                         input int bx, input int by, input int bvx, input int bvy,
                                         input bit known = 1'b0, input int given_dist = 0);
      encounter_type e;
      e.p1x = sca_pkg::PosW'(ax);
      e.p1y = sca_pkg::PosW'(ay);
      e.v1x = sca_pkg::VelW'(avx);
      e.v1y = sca_pkg::VelW'(avy);
      e.p2x = sca_pkg::PosW'(bx);
      e.p2y = sca_pkg::PosW'(by);
      e.v2x = sca_pkg::VelW'(bvx);
      e.v2y = sca_pkg::VelW'(bvy);
      e.known = known;
      e.given_dist = sca_pkg::DistW'(given_dist);
      return e;
   endfunction

   function automatic longint clip_velocity(input longint v);
      if (v > VelLimit) return VelLimit;
      if (v < -VelLimit) return -VelLimit;
      return v;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Samples both tracks across the frame and returns the floor root of the
   // least squared separation, with the number of samples taken.
   function automatic logic [sca_pkg::DistW-1:0] closest_distance_of(input encounter_type e,
                                                                     output int samples,
                                                                     output bit clipped);
      longint vel[4];
      longint span;
      longint best;
      longint sq;
      longint dx;
      longint dy;
      longint root;
      longint trial;
      vel[0] = clip_velocity(e.v1x);
      vel[1] = clip_velocity(e.v1y);
      vel[2] = clip_velocity(e.v2x);
      vel[3] = clip_velocity(e.v2y);
      clipped = (vel[0] != e.v1x) || (vel[1] != e.v1y) || (vel[2] != e.v2x) || (vel[3] != e.v2y);
      span = 1;
      foreach (vel[k]) begin
         if (magnitude(vel[k]) > span) span = magnitude(vel[k]);
      end
      best = -1;
      samples = 0;
      for (longint i = 0; i * sca_pkg::FracOne <= span; i++) begin
         dx = (longint'(e.p1x) + (vel[0] * i * sca_pkg::FracOne) / span)
            - (longint'(e.p2x) + (vel[2] * i * sca_pkg::FracOne) / span);
         dy = (longint'(e.p1y) + (vel[1] * i * sca_pkg::FracOne) / span)
            - (longint'(e.p2y) + (vel[3] * i * sca_pkg::FracOne) / span);
         sq = dx * dx + dy * dy;
         if (best < 0 || sq < best) best = sq;
         samples++;
      end
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= best) root = trial;
      end
      if (root > DistMax) root = DistMax;
      return sca_pkg::DistW'(root);
   endfunction

   task automatic offer(input encounter_type e, input int gap);
      int samples;
      bit clipped;
      logic [sca_pkg::DistW-1:0] predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_pos_x <= e.p1x;
      req_first_pos_y <= e.p1y;
      req_first_vel_x <= e.v1x;
      req_first_vel_y <= e.v1y;
      req_second_pos_x <= e.p2x;
      req_second_pos_y <= e.p2y;
      req_second_vel_x <= e.v2x;
      req_second_vel_y <= e.v2y;
      do @(posedge clock); while (!req_ready);
      predicted = closest_distance_of(e, samples, clipped);
      distance_q = {distance_q, (e.known ? e.given_dist : predicted)};
      sent_count++;
      if (clipped) clipped_count++;
      if (samples == 1) single_sample_count++;
   endtask

   initial begin
      encounter_type e;
      int ax, ay, avx, avy, bx, by, bvx, bvy;
      int kind;
      int frac;
      int gap;
      bit calm;
      directed = {directed, row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0)};
      directed = {directed, row(16, 0, 0, 0, 0, 0, 0, 0, 1'b1, 16)};
      directed = {directed, row(-32768, -32768, 0, 0, 32767, 32767, 0, 0, 1'b1, 92680)};
      directed = {directed, row(-32768, 0, 0, 0, 32767, 0, 0, 0, 1'b1, 65535)};
      directed = {directed, row(0, 0, 1024, 0, 1024, 0, -1024, 0, 1'b1, 0)};
      directed = {directed, row(0, 0, 2047, 0, 1024, 0, -2048, 0, 1'b1, 0)};
      directed = {directed, row(0, 0, 1, 0, 100, 0, 0, 0, 1'b1, 100)};
      directed = {directed, row(0, 0, 15, 0, 100, 0, 0, 0, 1'b1, 100)};
      directed = {directed, row(0, 0, 0, 0, 48, 64, 0, 0, 1'b1, 80)};
      directed = {directed, row(0, 0, 700, -300, 48, 64, 700, -300, 1'b1, 80)};
      directed = {directed, row(32767, 32767, 1024, 1024, 32767, 32767, -1024, -1024, 1'b1, 0)};
      directed = {directed, row(0, 0, 16, 0, 100, 0, 0, 0)};
      directed = {directed, row(0, 0, 17, -3, 100, 40, 0, 0)};
      directed = {directed, row(0, 0, 0, -1024, 0, -512, 0, 0)};
      directed = {directed, row(5, -7, -1000, 333, -50, 60, 999, -1001)};
      directed = {directed, row(-300, 900, -2048, -2048, 400, -200, -2048, 2047)};
      directed = {directed, row(32767, -32768, 2047, 2047, -32768, 32767, 2047, 2047)};
      directed = {directed, row(100, 100, 1025, -1025, -100, 300, -1024, 1024)};
      directed = {directed, row(0, 0, -1, -1, 3, 5, 1, 1)};
      directed = {directed, row(-32768, 32767, 1024, -1024, 32767, -32768, -1024, 1024)};
      directed = {directed, row(1234, -4321, -777, 555, 9000, 6000, -1023, -1023)};

      @(posedge clock);
      while (reset) @(posedge clock);

      calm = 1'b0;
      foreach (directed[n]) begin
         gap = calm ? 0 : $urandom_range(0, 16);
         offer(directed[n], gap);
      end

      for (int n = 0; n < RandomEncounters; n++) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         avx = int'($urandom_range(0, 2048)) - 1024;
         avy = int'($urandom_range(0, 2048)) - 1024;
         bvx = int'($urandom_range(0, 2048)) - 1024;
         bvy = int'($urandom_range(0, 2048)) - 1024;
         ax = int'($urandom_range(0, 32000)) - 16000;
         ay = int'($urandom_range(0, 32000)) - 16000;
         bx = int'($urandom_range(0, 65535)) - 32768;
         by = int'($urandom_range(0, 65535)) - 32768;
         if (kind <= 4) begin
            // The tracks cross near a random point of the frame.
            frac = $urandom_range(0, 16);
            bx = ax + ((avx - bvx) * frac) / 16 + int'($urandom_range(0, 64)) - 32;
            by = ay + ((avy - bvy) * frac) / 16 + int'($urandom_range(0, 64)) - 32;
         end else if (kind <= 6) begin
            ax = int'($urandom_range(0, 65535)) - 32768;
            ay = int'($urandom_range(0, 65535)) - 32768;
            avx = int'($urandom_range(0, 4095)) - 2048;
            bvy = int'($urandom_range(0, 4095)) - 2048;
         end else if (kind == 7) begin
            avx = int'($urandom_range(0, 40)) - 20;
            avy = int'($urandom_range(0, 40)) - 20;
            bvx = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 40)) - 20;
            bvy = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 40)) - 20;
            bx = ax + int'($urandom_range(0, 400)) - 200;
            by = ay + int'($urandom_range(0, 400)) - 200;
         end else if (kind == 8) begin
            ax = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            by = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            bx = ($urandom_range(0, 2) == 0) ? ax : -ax - 1;
         end else begin
            avx = int'($urandom_range(0, 4095)) - 2048;
            avy = int'($urandom_range(0, 4095)) - 2048;
            bvx = int'($urandom_range(0, 4095)) - 2048;
            bvy = int'($urandom_range(0, 4095)) - 2048;
         end
         e = row(ax, ay, avx, avy, bx, by, bvx, bvy);
         gap = calm ? 0 : $urandom_range(0, 16);
         offer(e, gap);
      end
      req_valid <= 1'b0;

      while (distance_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (distance_q.size() != 0) begin
         $error("closest_distance: %0d results never arrived", distance_q.size());
         fail_count++;
      end
      $display("Drove %0d encounters and checked %0d closest distances.", sent_count,
               checked_count);
      $display("%0d had a velocity clipped at the speed limit, %0d took a single sample.",
               clipped_count, single_sample_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      int stall;
      bit calm;
      logic [sca_pkg::DistW-1:0] want;
      calm = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (checked_count % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 16);
         // One long hold-off lets the block fill up and push back on its input.
         if (checked_count == PressureAfter) stall = PressureCycles;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (distance_q.size() == 0) begin
            $error("closest_distance: no result expected, actual %0d", rsp_closest_distance);
            fail_count++;
         end else begin
            want = distance_q.pop_front();
            if (rsp_closest_distance !== want) begin
               $error("closest_distance: expected %0d, actual %0d", want, rsp_closest_distance);
               fail_count++;
            end
         end
         checked_count++;
      end
   end

endmodule
